### sv/adsr_pkg.sv
// Shared types and register map for the ADSR envelope generator.
package adsr_pkg;

  typedef enum logic [1:0] {
    STG_IDLE    = 2'd0,
    STG_ATTACK  = 2'd1,
    STG_DECAY   = 2'd2,
    STG_RELEASE = 2'd3
  } stage_t;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_ATTACK_COEFF  = 3'd0;
  localparam reg_idx_t REG_DECAY_COEFF   = 3'd1;
  localparam reg_idx_t REG_RELEASE_COEFF = 3'd2;
  localparam reg_idx_t REG_SUSTAIN_LEVEL = 3'd3;
  localparam reg_idx_t REG_GATE_PATCHED  = 3'd4;

endpackage

### sv/adsr_envelope_generator_unit.sv
// Exponential ADSR envelope generator with APB-style register port.
//
// Takes one sample word per clock, sustained, while the result is not stalled. An accepted
// sample word is held in the input register and its result word in the result register. The
// whole update of a tick (event decode, one signed multiply of the distance to the stage
// target by the stage coefficient, add, saturate and the stage clamps) sits between the input
// register and the result register, so the level register closes its loop through that
// logic alone. A stalled result holds the next word in the input register, and the input
// stalls once that register is full as well.
module adsr_envelope_generator_unit #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int COEFF_FRAC_BITS = 24,
  localparam int DATA_W = (COEFF_FRAC_BITS + 3 > 32) ? 64 : 32,
  localparam int PADDR_W = ((COEFF_FRAC_BITS + 3 > 32) ? 3 : 2) + 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [PADDR_W-1:0]                paddr,
  input  logic [DATA_W-1:0]                 pwdata,
  output logic [DATA_W-1:0]                 prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [LEVEL_FRAC_BITS+1:0] in_gate_sample,
  input  logic                              in_note_start,
  input  logic                              in_note_release,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [LEVEL_FRAC_BITS:0]          out_env_level,
  output logic [1:0]                        out_env_stage
);

  localparam int CW = COEFF_FRAC_BITS + 3;
  localparam int OW = LEVEL_FRAC_BITS + 1;
  localparam int GW = LEVEL_FRAC_BITS + 2;
  localparam int LW = LEVEL_FRAC_BITS + 4;
  localparam int DW = LW + 1;
  localparam int PW = DW + CW + 1;
  localparam int SW = PW - COEFF_FRAC_BITS;
  localparam int SUMW = SW + 1;
  localparam int ADDR_LSB = PADDR_W - 3;

  localparam int ONE_I = 1 << LEVEL_FRAC_BITS;
  localparam int TGT_ATTACK_I = (ONE_I * 101 + 50) / 100;
  localparam int TGT_RELEASE_I = -((ONE_I + 50) / 100);
  localparam int GATE_HALF_I = ONE_I / 2;

  localparam logic signed [LW-1:0] LVL_ONE = LW'(ONE_I);
  localparam logic signed [LW-1:0] LVL_ZERO = '0;
  localparam logic signed [LW-1:0] TGT_ATTACK = LW'(TGT_ATTACK_I);
  localparam logic signed [LW-1:0] TGT_RELEASE = LW'(TGT_RELEASE_I);
  localparam logic signed [LW-1:0] GATE_HALF = LW'(GATE_HALF_I);
  localparam logic signed [LW-1:0] LVL_MAX = {1'b0, {(LW-1){1'b1}}};
  localparam logic signed [LW-1:0] LVL_MIN = {1'b1, {(LW-1){1'b0}}};

  // configuration registers
  logic [CW-1:0] attack_coeff_r;
  logic [CW-1:0] decay_coeff_r;
  logic [CW-1:0] release_coeff_r;
  logic [OW-1:0] sustain_level_r;
  logic          gate_patched_r;

  adsr_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  assign reg_idx = paddr[PADDR_W-1:ADDR_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_coeff_r  <= CW'(151832);
      decay_coeff_r   <= CW'(3804);
      release_coeff_r <= CW'(3043);
      sustain_level_r <= OW'(32768);
      gate_patched_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        adsr_pkg::REG_ATTACK_COEFF:  attack_coeff_r  <= pwdata[CW-1:0];
        adsr_pkg::REG_DECAY_COEFF:   decay_coeff_r   <= pwdata[CW-1:0];
        adsr_pkg::REG_RELEASE_COEFF: release_coeff_r <= pwdata[CW-1:0];
        adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level_r <= pwdata[OW-1:0];
        adsr_pkg::REG_GATE_PATCHED:  gate_patched_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      adsr_pkg::REG_ATTACK_COEFF:  prdata = DATA_W'(attack_coeff_r);
      adsr_pkg::REG_DECAY_COEFF:   prdata = DATA_W'(decay_coeff_r);
      adsr_pkg::REG_RELEASE_COEFF: prdata = DATA_W'(release_coeff_r);
      adsr_pkg::REG_SUSTAIN_LEVEL: prdata = DATA_W'(sustain_level_r);
      adsr_pkg::REG_GATE_PATCHED:  prdata = DATA_W'(gate_patched_r);
      default:                     prdata = '0;
    endcase
  end

  // input register
  logic                 in_vld_r;
  logic signed [GW-1:0] gate_sample_r;
  logic                 note_start_r;
  logic                 note_release_r;
  logic                 advance;

  assign advance  = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      gate_sample_r  <= in_gate_sample;
      note_start_r   <= in_note_start;
      note_release_r <= in_note_release;
    end
  end

  // envelope state
  adsr_pkg::stage_t     stage_r, stage_nxt;
  logic signed [LW-1:0] level_r, level_nxt;
  logic                 gate_last_r, gate_last_nxt;

  adsr_pkg::stage_t     stage_evt;
  logic signed [LW-1:0] gate_ext;
  logic                 gate_high;
  logic signed [LW-1:0] sus;
  logic signed [LW-1:0] tgt;
  logic [CW-1:0]        coeff;

  assign gate_ext  = {{(LW-GW){gate_sample_r[GW-1]}}, gate_sample_r};
  assign gate_high = gate_ext > GATE_HALF;
  assign sus = ({{(LW-OW){1'b0}}, sustain_level_r} > LVL_ONE) ? LVL_ONE :
               {{(LW-OW){1'b0}}, sustain_level_r};

  // apply note and gate events in order, then pick target and coefficient
  always_comb begin
    stage_evt     = stage_r;
    gate_last_nxt = gate_last_r;
    if (note_start_r) stage_evt = adsr_pkg::STG_ATTACK;
    if (note_release_r) stage_evt = adsr_pkg::STG_RELEASE;
    if (gate_patched_r) begin
      if (gate_high && !gate_last_r) stage_evt = adsr_pkg::STG_ATTACK;
      if (!gate_high && gate_last_r) stage_evt = adsr_pkg::STG_RELEASE;
      gate_last_nxt = gate_high;
    end
    unique case (stage_evt)
      adsr_pkg::STG_ATTACK: begin
        tgt   = TGT_ATTACK;
        coeff = attack_coeff_r;
      end
      adsr_pkg::STG_DECAY: begin
        tgt   = sus;
        coeff = decay_coeff_r;
      end
      adsr_pkg::STG_RELEASE: begin
        tgt   = TGT_RELEASE;
        coeff = release_coeff_r;
      end
      default: begin
        tgt   = level_r;
        coeff = '0;
      end
    endcase
  end

  logic signed [DW-1:0]   diff;
  logic signed [CW:0]     coeff_s;
  logic signed [PW-1:0]   prod;
  logic signed [SW-1:0]   step;
  logic signed [SUMW-1:0] sum;
  logic                   sum_fits;
  logic signed [LW-1:0]   level_sat;

  assign diff     = {tgt[LW-1], tgt} - {level_r[LW-1], level_r};
  assign coeff_s  = {1'b0, coeff};
  assign prod     = diff * coeff_s;
  assign step     = prod[PW-1:COEFF_FRAC_BITS];
  assign sum      = {{(SUMW-LW){level_r[LW-1]}}, level_r} + {step[SW-1], step};
  assign sum_fits = (sum[SUMW-1:LW-1] == '0) || (sum[SUMW-1:LW-1] == '1);
  assign level_sat = sum_fits ? sum[LW-1:0] : (sum[SUMW-1] ? LVL_MIN : LVL_MAX);

  // next state: stage clamps
  always_comb begin
    stage_nxt = stage_evt;
    level_nxt = level_sat;
    unique case (stage_evt)
      adsr_pkg::STG_ATTACK: begin
        if (level_sat >= LVL_ONE) begin
          level_nxt = LVL_ONE;
          stage_nxt = adsr_pkg::STG_DECAY;
        end
      end
      adsr_pkg::STG_DECAY: ;
      adsr_pkg::STG_RELEASE: begin
        if (level_sat <= LVL_ZERO) begin
          level_nxt = '0;
          stage_nxt = adsr_pkg::STG_IDLE;
        end
      end
      default: level_nxt = level_r;
    endcase
  end

  // outputs: clamp level to 0..1.0
  logic [OW-1:0] env_level_nxt;

  always_comb begin
    if (level_nxt < LVL_ZERO) begin
      env_level_nxt = '0;
    end else if (level_nxt > LVL_ONE) begin
      env_level_nxt = LVL_ONE[OW-1:0];
    end else begin
      env_level_nxt = level_nxt[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= adsr_pkg::STG_IDLE;
      level_r     <= '0;
      gate_last_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        stage_r     <= stage_nxt;
        level_r     <= level_nxt;
        gate_last_r <= gate_last_nxt;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_env_level <= env_level_nxt;
      out_env_stage <= stage_nxt;
    end
  end

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_env_level <= LVL_ONE[OW-1:0])
    else $error("envelope level above full scale");

  a_idle_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_env_stage == adsr_pkg::STG_IDLE) |-> out_env_level == '0)
    else $error("idle stage with nonzero level");

  a_release_wins: assert property (@(posedge clk) disable iff (!rst_n)
    advance && note_release_r && !gate_patched_r |=>
      (stage_r == adsr_pkg::STG_RELEASE) || (stage_r == adsr_pkg::STG_IDLE))
    else $error("note release did not force release");

endmodule
